FILE: sv/cfr_pkg.sv
`timescale 1ns / 1ps
package cfr_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int WORD_WIDTH_DEF = 32;
	localparam int ITEM_W         = 32;
	localparam int OCC_W          = 5;

	typedef enum logic [1:0] {
		OP_PUSH  = 2'd0,
		OP_POP   = 2'd1,
		OP_CYCLE = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef enum logic {
		ST_IDLE,
		ST_READ
	} state_t;

	typedef struct packed {
		op_t               opcode;
		logic [ITEM_W-1:0] item_in;
	} in_item_t;

	typedef struct packed {
		logic              ok;
		logic [ITEM_W-1:0] item_out;
		logic              is_empty;
		logic              is_full;
		logic [OCC_W-1:0]  occupancy;
	} out_item_t;

endpackage

FILE: sv/cfr_ram.sv
`timescale 1ns / 1ps
module cfr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: sv/cfr_ctrl.sv
`timescale 1ns / 1ps
module cfr_ctrl
	import cfr_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  in_item_t                 in_data,
	output logic                     out_valid,
	input  logic                     out_ready,
	output out_item_t                out_data,
	output logic                     wr_en,
	output logic [$clog2(DEPTH)-1:0] wr_addr,
	output logic [WORD_WIDTH-1:0]    wr_data,
	output logic                     rd_en,
	output logic [$clog2(DEPTH)-1:0] rd_addr,
	input  logic [WORD_WIDTH-1:0]    rd_data
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	state_t           state_q, state_d;
	op_t              op_s1, op_d;
	logic [IDX_W-1:0] head_q, head_d;
	logic [IDX_W-1:0] tail_q, tail_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [IDX_W-1:0] head_next, tail_next;
	logic             full, word_nz, load_out, accept;
	out_item_t        res;
	out_item_t        out_data_q;
	logic             out_valid_q;

	assign head_next = (head_q == IDX_W'(DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign tail_next = (tail_q == IDX_W'(DEPTH - 1)) ? '0 : tail_q + 1'b1;
	assign full      = (cnt_q == CNT_W'(DEPTH));
	assign word_nz   = (rd_data != '0);
	assign accept    = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			tail_q      <= IDX_W'(DEPTH - 1);
			cnt_q       <= '0;
			op_s1       <= OP_NOP;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			cnt_q   <= cnt_d;
			op_s1   <= op_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q <= res;
		end
	end

	always_comb begin
		state_d      = state_q;
		op_d         = op_s1;
		head_d       = head_q;
		tail_d       = tail_q;
		cnt_d        = cnt_q;
		in_ready     = 1'b0;
		load_out     = 1'b0;
		wr_en        = 1'b0;
		wr_addr      = tail_next;
		wr_data      = WORD_WIDTH'(in_data.item_in);
		rd_en        = 1'b0;
		rd_addr      = head_q;
		res.ok       = 1'b0;
		res.item_out = '0;
		unique case (state_q)
			ST_IDLE: begin
				// a pop result lands in the following cycle, so the output slot must free up now
				in_ready = !out_valid_q || out_ready;
				if (accept) begin
					case (in_data.opcode) inside
						OP_PUSH: begin
							load_out = 1'b1;
							if (!full) begin
								wr_en  = 1'b1;
								tail_d = tail_next;
								cnt_d  = cnt_q + 1'b1;
								res.ok = 1'b1;
							end
						end
						OP_POP, OP_CYCLE: begin
							if (cnt_q != '0) begin
								rd_en   = 1'b1;
								head_d  = head_next;
								cnt_d   = cnt_q - 1'b1;
								op_d    = in_data.opcode;
								state_d = ST_READ;
							end else begin
								load_out = 1'b1;
							end
						end
						default: begin
							load_out = 1'b1;
						end
					endcase
				end
			end
			ST_READ: begin
				load_out = 1'b1;
				state_d  = ST_IDLE;
				res.ok   = word_nz;
				if (word_nz) begin
					res.item_out = ITEM_W'(rd_data);
				end
				// reinsert a nonzero head at the tail; drop a null head
				if (op_s1 == OP_CYCLE && word_nz) begin
					wr_en   = 1'b1;
					wr_data = rd_data;
					tail_d  = tail_next;
					cnt_d   = cnt_q + 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		res.is_empty  = (cnt_d == '0);
		res.is_full   = (cnt_d == CNT_W'(DEPTH));
		res.occupancy = OCC_W'(cnt_d);
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

FILE: sv/circular_fifo_with_rotate_unit.sv
`timescale 1ns / 1ps
// Ring-buffer FIFO with a head-to-tail rotate.
// Input channel (in_valid/in_ready/in_data): opcode push, pop or cycle plus a word.
// Output channel (out_valid/out_ready/out_data): one result per item with ok,
// the word removed or rotated, and empty/full/occupancy after the step.
// Push, a pop or cycle on an empty queue, and the unused opcode load their
// result into the output register on acceptance. A pop or cycle on a nonempty
// queue reads the head slot from the synchronous RAM, moves to the read state
// and loads its result from there; no new item is taken in the read state.
// Throughput: one item per cycle, while the receiver takes results, for push,
// the unused opcode and pop or cycle on an empty queue; on a nonempty queue a
// pop or cycle blocks the next item until its registered slot RAM read is done.
// A cycle that finds a zero head drops it instead of writing it back.
// Reset sets head and count to zero, points tail at the last slot and empties
// the output register; the slot RAM is not cleared, since only written slots
// are ever read.
// When the receiver stalls, the result holds in the output register and no
// new item is accepted until that result is taken or is being taken.
module circular_fifo_with_rotate_unit
	import cfr_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	localparam int IDX_W = $clog2(DEPTH);

	logic                  wr_en, rd_en;
	logic [IDX_W-1:0]      wr_addr, rd_addr;
	logic [WORD_WIDTH-1:0] wr_data, rd_data;

	cfr_ctrl #(
		.DEPTH      (DEPTH),
		.WORD_WIDTH (WORD_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data)
	);

	cfr_ram #(
		.WIDTH (WORD_WIDTH),
		.DEPTH (DEPTH)
	) u_slots (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

`ifndef SYNTHESIS
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("item accepted while a stalled result occupies the output");

	a_not_ok_zero_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.ok |-> out_data.item_out == '0)
		else $error("nonzero word reported with ok low");

	a_empty_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.is_empty |-> !out_data.is_full && out_data.occupancy == '0)
		else $error("empty flag disagrees with occupancy or full");
`endif

endmodule

FILE: tb/fifo_result_checker.sv
`timescale 1ns / 1ps
module fifo_result_checker
	import cfr_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_ready,
	input  in_item_t  in_data,
	input  logic      out_valid,
	input  logic      out_ready,
	input  out_item_t out_data,
	output int        fail_count,
	output int        pending,
	output int        results_seen
);

	localparam logic [ITEM_W-1:0] WORD_MASK = (WORD_WIDTH >= ITEM_W) ? {ITEM_W{1'b1}} :
		((ITEM_W'(1) << WORD_WIDTH) - ITEM_W'(1));

	logic [ITEM_W-1:0] ring [DEPTH];
	int head_pos;
	int tail_pos;
	int held;
	int errors;
	int checked;
	out_item_t fifo_replies [$];
	out_item_t predicted;
	out_item_t oldest;

	function automatic int wrap_next(input int i);
		return (i + 1 >= DEPTH) ? 0 : i + 1;
	endfunction

	task automatic rotate_fifo_step(input in_item_t it, output out_item_t res);
		logic [ITEM_W-1:0] word;
		logic ok;
		word = '0;
		ok = 1'b0;
		case (it.opcode)
			OP_PUSH: begin
				if (held < DEPTH) begin
					tail_pos = wrap_next(tail_pos);
					ring[tail_pos] = it.item_in & WORD_MASK;
					held++;
					ok = 1'b1;
				end
			end
			OP_POP, OP_CYCLE: begin
				if (held > 0) begin
					word = ring[head_pos];
					head_pos = wrap_next(head_pos);
					held--;
				end
				ok = (word != '0);
				// put a nonzero head back at the tail; a zero head is dropped
				if (it.opcode == OP_CYCLE && ok) begin
					tail_pos = wrap_next(tail_pos);
					ring[tail_pos] = word;
					held++;
				end
			end
			default: ;
		endcase
		res.ok        = ok;
		res.item_out  = word;
		res.is_empty  = (held == 0);
		res.is_full   = (held >= DEPTH);
		res.occupancy = OCC_W'(held);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_pos = 0;
			tail_pos = DEPTH - 1;
			held     = 0;
			errors   = 0;
			checked  = 0;
			fifo_replies.delete();
		end else begin
			// compare before predicting: no item gets its result in its own accept cycle
			if (out_valid && out_ready) begin
				checked++;
				if (fifo_replies.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("[%0t] unexpected result: ok=%0b word=%h empty=%0b full=%0b occ=%0d",
							$realtime, out_data.ok, out_data.item_out, out_data.is_empty,
							out_data.is_full, out_data.occupancy);
				end else begin
					oldest = fifo_replies.pop_front();
					if (out_data.ok !== oldest.ok || out_data.item_out !== oldest.item_out ||
						out_data.is_empty !== oldest.is_empty ||
						out_data.is_full !== oldest.is_full ||
						out_data.occupancy !== oldest.occupancy) begin
						errors++;
						if (errors <= 10) begin
							$display("[%0t] mismatch: expected ok=%0b word=%h empty=%0b full=%0b occ=%0d",
								$realtime, oldest.ok, oldest.item_out, oldest.is_empty,
								oldest.is_full, oldest.occupancy);
							$display("            actual   ok=%0b word=%h empty=%0b full=%0b occ=%0d",
								out_data.ok, out_data.item_out, out_data.is_empty,
								out_data.is_full, out_data.occupancy);
						end
					end
				end
			end
			if (in_valid && in_ready) begin
				rotate_fifo_step(in_data, predicted);
				fifo_replies.push_back(predicted);
			end
		end
		fail_count   <= errors;
		pending      <= fifo_replies.size();
		results_seen <= checked;
	end

endmodule

FILE: tb/circular_fifo_with_rotate_unit_tb.sv
`timescale 1ns / 1ps
module circular_fifo_with_rotate_unit_tb;
	import cfr_pkg::*;

	localparam int DEPTH          = DEPTH_DEF;
	localparam int WORD_WIDTH     = WORD_WIDTH_DEF;
	localparam int RANDOM_ITEMS   = 1450;
	localparam int STALL_LIMIT    = 2000;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_ready;
	in_item_t  in_data   = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_data;

	int fail_count;
	int pending;
	int results_seen;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int quiet = 0;
	int op_sent [4] = '{0, 0, 0, 0};

	circular_fifo_with_rotate_unit #(
		.DEPTH(DEPTH),
		.WORD_WIDTH(WORD_WIDTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	fifo_result_checker #(
		.DEPTH(DEPTH),
		.WORD_WIDTH(WORD_WIDTH)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.fail_count(fail_count),
		.pending(pending),
		.results_seen(results_seen)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet <= 0;
			end else begin
				quiet <= quiet + 1;
				if (quiet >= STALL_LIMIT) begin
					$display("Verification failed");
					$finish;
				end
			end
		end
	end

	task automatic send_item(input op_t op, input logic [ITEM_W-1:0] word);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= in_item_t'{opcode: op, item_in: word};
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		op_sent[op]++;
	endtask

	// hold the sender off until every outstanding result has drained
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	function automatic logic [ITEM_W-1:0] pick_word();
		case ($urandom_range(9))
			0:       return '0;
			1:       return '1;
			2:       return ITEM_W'(1) << $urandom_range(ITEM_W - 1);
			default: return $urandom;
		endcase
	endfunction

	function automatic op_t pick_op(input int bias);
		int r;
		r = $urandom_range(99);
		if (r < 4)
			return OP_NOP;
		case (bias)
			0:       return (r < 70) ? OP_PUSH : (r < 85) ? OP_POP : OP_CYCLE;
			1:       return (r < 25) ? OP_PUSH : (r < 75) ? OP_POP : OP_CYCLE;
			2:       return (r < 35) ? OP_PUSH : (r < 55) ? OP_POP : OP_CYCLE;
			default: return (r < 45) ? OP_PUSH : (r < 72) ? OP_POP : OP_CYCLE;
		endcase
	endfunction

	task automatic random_phase(input int count);
		int done;
		int burst;
		int bias;
		done = 0;
		while (done < count) begin
			// bursts of one bias drive the queue to full, to empty and around the ring
			burst = $urandom_range(8, 40);
			bias  = $urandom_range(3);
			for (int i = 0; i < burst && done < count; i++) begin
				send_item(pick_op(bias), pick_word());
				done++;
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(OP_POP,   32'h1234_5678);
		send_item(OP_CYCLE, 32'h0000_0000);
		send_item(OP_PUSH,  32'h0000_0000);
		send_item(OP_PUSH,  32'hFFFF_FFFF);
		send_item(OP_CYCLE, 32'hFFFF_FFFF);
		send_item(OP_CYCLE, 32'h0000_0000);
		send_item(OP_POP,   32'h0000_0000);
		send_item(OP_PUSH,  32'h0000_0000);
		send_item(OP_POP,   32'hFFFF_FFFF);
		for (int i = 0; i < DEPTH; i++)
			send_item(OP_PUSH, (i == 0) ? 32'h8000_0001 : (ITEM_W'(1) << (i * 2)) | i);
		send_item(OP_PUSH,  32'hDEAD_BEEF);
		send_item(OP_CYCLE, 32'h0000_0000);
		send_item(OP_NOP,   32'hFFFF_FFFF);
		drain_results();

		tx_idle_pct = 29;
		rx_idle_pct = 85;
		random_phase(RANDOM_ITEMS / 3);
		drain_results();

		tx_idle_pct = 85;
		rx_idle_pct = 29;
		random_phase(RANDOM_ITEMS / 3);
		drain_results();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		random_phase(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

		drain_results();
		repeat (20) @(posedge clk);

		$display("Items sent: %0d push, %0d pop, %0d cycle, %0d unused opcode",
			op_sent[OP_PUSH], op_sent[OP_POP], op_sent[OP_CYCLE], op_sent[OP_NOP]);
		$display("Results checked: %0d over slow-sender, slow-receiver and full-rate phases",
			results_seen);
		if (fail_count == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
